// ===== hdl/tiled_4bpp_glyph_blit_defines.svh =====
// Assertion helpers used by the blitter back end
`ifndef TILED_4BPP_GLYPH_BLIT_DEFINES_SVH
`define TILED_4BPP_GLYPH_BLIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define TGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tgb_pkg.sv =====
package tgb_pkg;

    localparam int TILE_PIXELS      = 8;
    localparam int DEF_MAX_TILES    = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam int TILES_W          = 6;
    localparam int OFFSET_W         = 15;
    localparam int PX_W             = 9;

    // register indexes on the configuration port
    localparam logic REG_WIDTH_TILES  = 1'b0;
    localparam logic REG_HEIGHT_TILES = 1'b1;

    // one classified glyph row waiting to be expanded into nibble writes
    typedef struct packed {
        logic [31:0]          pixel_row;
        logic [7:0]           mask;      // opaque, in-range columns
        logic [PX_W-1:0]      px_base;   // pixel column of column 0
        logic [OFFSET_W-1:0]  row_off;   // byte offset of the target pixel row
    } tgb_entry_t;

endpackage

// ===== hdl/tgb_front.sv =====
module tgb_front
    import tgb_pkg::*;
(
    input  logic [TILES_W-1:0] width_tiles,
    input  logic [TILES_W-1:0] height_tiles,
    input  logic [31:0]        pixel_row,
    input  logic [1:0]         quadrant,
    input  logic [2:0]         row_in_quadrant,
    input  logic [7:0]         origin_x,
    input  logic [7:0]         origin_y,
    input  logic [4:0]         glyph_width,
    input  logic [4:0]         glyph_height,
    output tgb_entry_t         entry,
    output logic               has_writes
);

    logic signed [9:0]  span_x;
    logic signed [9:0]  span_y;
    logic signed [9:0]  qcols;
    logic signed [9:0]  qrows;
    logic               row_ok;
    logic [PX_W-1:0]    py;
    logic [11:0]        tile_row_prod;
    logic [16:0]        row_bytes;
    logic [7:0]         mask;

    always_comb begin
        span_x = $signed({1'b0, width_tiles, 3'b000}) - $signed({2'b00, origin_x});
        if (span_x > $signed({5'b00000, glyph_width})) begin
            span_x = $signed({5'b00000, glyph_width});
        end
        span_y = $signed({1'b0, height_tiles, 3'b000}) - $signed({2'b00, origin_y});
        if (span_y > $signed({5'b00000, glyph_height})) begin
            span_y = $signed({5'b00000, glyph_height});
        end

        // right and bottom quadrants take whatever lies beyond the first eight
        qcols = quadrant[0] ? span_x - 10'sd8 : span_x;
        if (qcols > 10'sd8) begin
            qcols = 10'sd8;
        end
        qrows = quadrant[1] ? span_y - 10'sd8 : span_y;
        if (qrows > 10'sd8) begin
            qrows = 10'sd8;
        end

        row_ok = (span_x > 10'sd0) && (span_y > 10'sd0) && (qcols > 10'sd0)
                 && ($signed({7'b0000000, row_in_quadrant}) < qrows);

        for (int c = 0; c < 8; c++) begin
            mask[c] = row_ok && ($signed(10'(c)) < qcols) && (pixel_row[4*c +: 4] != 4'h0);
        end

        py            = {1'b0, origin_y} + {5'b00000, quadrant[1], 3'b000}
                        + {6'b000000, row_in_quadrant};
        tile_row_prod = {6'b000000, py[8:3]} * {6'b000000, width_tiles};
        row_bytes     = {tile_row_prod, 5'b00000};
    end

    assign entry.pixel_row = pixel_row;
    assign entry.mask      = mask;
    assign entry.px_base   = {1'b0, origin_x} + {5'b00000, quadrant[0], 3'b000};
    assign entry.row_off   = row_bytes[OFFSET_W-1:0] + {10'b0, py[2:0], 2'b00};
    assign has_writes      = |mask;

endmodule

// ===== hdl/tgb_queue.sv =====
module tgb_queue
    import tgb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  tgb_entry_t push_entry,
    input  logic       pop,
    output tgb_entry_t head,
    output logic       not_empty,
    output logic       full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tgb_entry_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

endmodule

// ===== hdl/tgb_back.sv =====
`include "tiled_4bpp_glyph_blit_defines.svh"

module tgb_back
    import tgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tgb_entry_t  head,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    logic [7:0]          done_reg, done_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [3:0]          color_reg;
    logic                high_reg;
    logic                last_reg;

    logic [7:0]          pending;
    logic [7:0]          pick;
    logic [7:0]          remain;
    logic [2:0]          col;
    logic [PX_W-1:0]     px;
    logic [OFFSET_W-1:0] offset;
    logic                load;

    always_comb begin
        pending = head.mask & ~done_reg;
        pick    = pending & (~pending + 8'd1);   // lowest opaque column left
        remain  = pending & ~pick;
        col     = '0;
        for (int i = 0; i < 8; i++) begin
            if (pick[i]) begin
                col = 3'(i);
            end
        end
        px     = head.px_base + {6'b000000, col};
        offset = head.row_off + {4'b0000, px[8:3], 5'b00000} + {13'b0, px[2:1]};

        load = head_valid && (!m_tvalid_reg || m_tready);
        pop  = load && (remain == 8'h00);

        if (pop) begin
            done_next = '0;
        end else if (load) begin
            done_next = done_reg | pick;
        end else begin
            done_next = done_reg;
        end

        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            offset_reg <= offset;
            color_reg  <= head.pixel_row[4*col +: 4];
            high_reg   <= px[0];
            last_reg   <= (remain == 8'h00);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, color_reg, offset_reg};
    assign m_tuser  = high_reg;
    assign m_tlast  = last_reg;

    `TGB_ASSERT_NXT(a_pop_gives_last, aclk, aresetn, pop, m_tvalid && m_tlast, "row retired without a last write")
    `TGB_ASSERT_IMP(a_done_in_mask, aclk, aresetn, head_valid, (done_reg & ~head.mask) == 8'h00, "done bits outside row mask")
    `TGB_ASSERT_IMP(a_done_clear_idle, aclk, aresetn, !head_valid, done_reg == 8'h00, "done bits left with queue empty")
    `TGB_ASSERT_IMP(a_one_pick, aclk, aresetn, load, $onehot(pick), "write issued without exactly one column")

endmodule

// ===== hdl/tiled_4bpp_glyph_blit.sv =====
// A row's first nibble write reaches m_ through the row queue and then the output register.
// The expander issues one write per cycle while m_tready allows; a row with k opaque
// in-range pixels gives k writes, and a row that writes nothing never enters the queue.
// Input side is limited by a two-entry row queue ahead of the one-per-cycle expander.
// Reset (synchronous, aresetn low): window width and height return to one tile,
// the queue empties and m_tvalid drops.
module tiled_4bpp_glyph_blit
    import tgb_pkg::*;
#(
    parameter int MAX_WINDOW_TILES = DEF_MAX_TILES
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_row[31:0], quadrant[33:32], row_in_quadrant[36:34], origin_x[44:37],
    // origin_y[52:45], glyph_width[57:53], glyph_height[62:58]
    input  logic [63:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_offset[14:0], pixel_color[18:15]
    output logic [23:0] m_tdata,
    // high_nibble[0]
    output logic        m_tuser,
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TILES_W-1:0] width_tiles_reg, width_tiles_next;
    logic [TILES_W-1:0] height_tiles_reg, height_tiles_next;
    logic [TILES_W-1:0] wr_tiles;
    logic               cfg_write;

    tgb_entry_t         front_entry;
    tgb_entry_t         head;
    logic               has_writes;
    logic               q_not_empty;
    logic               q_full;
    logic               q_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign wr_tiles  = (pwdata[TILES_W-1:0] > TILES_W'(MAX_WINDOW_TILES))
                       ? TILES_W'(MAX_WINDOW_TILES) : pwdata[TILES_W-1:0];

    always_comb begin
        width_tiles_next  = width_tiles_reg;
        height_tiles_next = height_tiles_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_WIDTH_TILES:  width_tiles_next  = wr_tiles;
                REG_HEIGHT_TILES: height_tiles_next = wr_tiles;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_tiles_reg  <= TILES_W'(1);
            height_tiles_reg <= TILES_W'(1);
        end else begin
            width_tiles_reg  <= width_tiles_next;
            height_tiles_reg <= height_tiles_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH_TILES:  prdata = {26'b0, width_tiles_reg};
            REG_HEIGHT_TILES: prdata = {26'b0, height_tiles_reg};
            default:          prdata = '0;
        endcase
    end

    assign s_tready = !q_full;

    tgb_front u_front (
        .width_tiles     (width_tiles_reg),
        .height_tiles    (height_tiles_reg),
        .pixel_row       (s_tdata[31:0]),
        .quadrant        (s_tdata[33:32]),
        .row_in_quadrant (s_tdata[36:34]),
        .origin_x        (s_tdata[44:37]),
        .origin_y        (s_tdata[52:45]),
        .glyph_width     (s_tdata[57:53]),
        .glyph_height    (s_tdata[62:58]),
        .entry           (front_entry),
        .has_writes      (has_writes)
    );

    tgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid && s_tready && has_writes),
        .push_entry (front_entry),
        .pop        (q_pop),
        .head       (head),
        .not_empty  (q_not_empty),
        .full       (q_full)
    );

    tgb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
